@@ sv/sdss_pkg.sv @@
// shared constants, types and functions of the signed decimal seven-segment driver
package sdss_pkg;

	localparam int MAX_DIGITS = 8;
	localparam int DATA_W     = 32;
	localparam int COUNT_W    = 4;
	localparam int ROW_W      = 4;
	localparam int ROW_MAP_W  = 32;
	localparam int MAP_SLOTS  = ROW_MAP_W / ROW_W;
	localparam int SEG_W      = 7;
	localparam int POS_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int LEN_W      = 4;
	localparam int CFG_IDX_W  = 1;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ROW_MAP     = CFG_IDX_W'(1);

	localparam logic [COUNT_W-1:0]   DIGIT_COUNT_RST = COUNT_W'(1);
	localparam logic [ROW_MAP_W-1:0] ROW_MAP_RST     = 32'h7654_3210;

	typedef logic [SEG_W-1:0] seg_t;

	localparam seg_t SEG_BLANK = 7'h00;
	localparam seg_t SEG_MINUS = 7'h40;
	localparam seg_t SEG_NINE  = 7'h6f;

	// ceil(2^35 / 10), exact quotient by ten for every 32-bit operand via >> 35
	localparam logic [DATA_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
	localparam int                RECIP_SH  = 35;

	localparam logic [DATA_W-1:0] POW10 [1:9] = '{
		32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
		32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
	};

	function automatic seg_t seg_of_digit(input logic [3:0] d);
		seg_t s;
		case (d)
			4'd0:    s = 7'h3f;
			4'd1:    s = 7'h06;
			4'd2:    s = 7'h5b;
			4'd3:    s = 7'h4f;
			4'd4:    s = 7'h66;
			4'd5:    s = 7'h6d;
			4'd6:    s = 7'h7d;
			4'd7:    s = 7'h07;
			4'd8:    s = 7'h7f;
			4'd9:    s = 7'h6f;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

	// number of decimal digits of an unsigned value, at least one
	function automatic logic [LEN_W-1:0] dec_len(input logic [DATA_W-1:0] mag);
		logic [LEN_W-1:0] len;
		len = LEN_W'(1);
		for (int k = 1; k <= 9; k++) begin
			if (mag >= POW10[k])
				len = len + LEN_W'(1);
		end
		return len;
	endfunction

endpackage

@@ sv/signed_decimal_seven_segment_top.sv @@
// top level of the signed decimal seven-segment driver
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------
//  in      | in_valid / in_stall  | number (32b signed)
//  out     | out_valid / out_stall| led_row (4b), segments (7b), last
//  cfg     | cfg_valid / cfg_ready| cfg_index (1b), cfg_data (32b)
//
// one word in gives digit_count words out, 8 at most, one per cycle while out_stall
// is low, set by the digit sequencer; a count of zero gives no words. the next word
// waits in the input register and follows with no gap; a word passes the input register,
// the sequencer and the output register. one quotient by ten per unstalled cycle, 32x32 multiply.
// reset clears all valid flags and loads digit_count = 1, row_map = 0x76543210.
// out_stall freezes the output register and the sequencer; cfg_ready is always high.
module signed_decimal_seven_segment_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [sdss_pkg::DATA_W-1:0]  number,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic        [sdss_pkg::ROW_W-1:0]   led_row,
	output logic        [sdss_pkg::SEG_W-1:0]   segments,
	output logic                                last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic        [sdss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [sdss_pkg::ROW_MAP_W-1:0] cfg_data
);
	import sdss_pkg::*;

	// configuration registers
	logic [COUNT_W-1:0]   digit_count_q;
	logic [ROW_MAP_W-1:0] row_map_q;

	// input register: sign and magnitude of the waiting word
	logic                 valid_s1;
	logic                 neg_s1;
	logic [DATA_W-1:0]    mag_s1;

	// digit sequencer
	logic                 busy_q;
	logic [DATA_W-1:0]    rem_q;     // value still to be split into digits
	logic                 neg_q;
	logic                 fits_q;
	logic [LEN_W-1:0]     len_q;
	logic [COUNT_W-1:0]   cnt_q;
	logic [POS_W-1:0]     pos_q;

	// output register
	logic                 out_valid_q;
	logic [ROW_W-1:0]     led_row_q;
	seg_t                 segments_q;
	logic                 last_q;

	logic                 issue;      // sequencer hands one result to the output register
	logic                 final_pos;  // current position is the top one
	logic                 load;       // waiting word moves into the sequencer
	logic [COUNT_W-1:0]   cnt_sat;
	logic [LEN_W-1:0]     len_s1;
	logic [LEN_W:0]       need_s1;
	logic [2*DATA_W-1:0]  prod;
	logic [DATA_W-1:0]    quot;
	logic [3:0]           digit;
	seg_t                 seg_nxt;
	logic [ROW_W-1:0]     row_nxt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= DIGIT_COUNT_RST;
			row_map_q     <= ROW_MAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_DIGIT_COUNT)
				digit_count_q <= cfg_data[COUNT_W-1:0];
			else if (cfg_index == REG_ROW_MAP)
				row_map_q <= cfg_data;
		end
	end

	// sequencer may produce a word whenever the output register is free or draining
	assign issue     = busy_q && (!out_valid_q || !out_stall);
	assign final_pos = (COUNT_W'(pos_q) == cnt_q - COUNT_W'(1));
	assign load      = valid_s1 && (!busy_q || (issue && final_pos));
	assign in_stall  = valid_s1 && !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			neg_s1 <= number[DATA_W-1];
			mag_s1 <= number[DATA_W-1] ? DATA_W'(-number) : DATA_W'(number);
		end
	end

	// digit count saturates at the supported width
	assign cnt_sat = (int'(digit_count_q) > MAX_DIGITS) ? COUNT_W'(MAX_DIGITS)
		: digit_count_q;
	assign len_s1  = dec_len(mag_s1);
	assign need_s1 = {1'b0, len_s1} + (LEN_W+1)'(neg_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= (cnt_sat != '0);  // zero positions: word gives no result
		end else if (issue && final_pos) begin
			busy_q <= 1'b0;
		end
	end

	// quotient and remainder by ten; only the low bits of q*10 matter for the digit
	assign prod  = {{DATA_W{1'b0}}, rem_q} * {{DATA_W{1'b0}}, RECIP_TEN};
	assign quot  = DATA_W'(prod[2*DATA_W-1:RECIP_SH]);
	assign digit = rem_q[3:0] - ({quot[0], 3'b000} + {quot[2:0], 1'b0});

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q  <= mag_s1;
			neg_q  <= neg_s1;
			len_q  <= len_s1;
			cnt_q  <= cnt_sat;
			fits_q <= (need_s1 <= (LEN_W+1)'(cnt_sat));
			pos_q  <= '0;
		end else if (issue) begin
			rem_q <= quot;
			pos_q <= pos_q + POS_W'(1);
		end
	end

	always_comb begin
		if (neg_q && cnt_q == COUNT_W'(1)) begin
			seg_nxt = SEG_MINUS;                      // single position shows the sign only
		end else if (!fits_q) begin
			seg_nxt = (neg_q && final_pos) ? SEG_MINUS : SEG_NINE;  // overflow
		end else if (LEN_W'(pos_q) < len_q) begin
			seg_nxt = seg_of_digit(digit);
		end else if (neg_q && LEN_W'(pos_q) == len_q) begin
			seg_nxt = SEG_MINUS;                      // sign just above the magnitude
		end else begin
			seg_nxt = SEG_BLANK;
		end
	end

	// positions past the row map get row zero
	always_comb begin
		if (int'(pos_q) < MAP_SLOTS)
			row_nxt = row_map_q[{pos_q, 2'b00} +: ROW_W];
		else
			row_nxt = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (issue) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			led_row_q  <= row_nxt;
			segments_q <= seg_nxt;
			last_q     <= final_pos;
		end
	end

	assign out_valid = out_valid_q;
	assign led_row   = led_row_q;
	assign segments  = segments_q;
	assign last      = last_q;

endmodule

@@ sv/sdss_checker.sv @@
// port-level checks of the signed decimal seven-segment driver and their binding
module sdss_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  out_valid,
	input logic                                  out_stall,
	input logic [sdss_pkg::ROW_W-1:0]            led_row,
	input logic [sdss_pkg::SEG_W-1:0]            segments,
	input logic                                  last
);
	import sdss_pkg::*;

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(segments) && $stable(led_row)
			&& $stable(last))
		else $error("stalled output word changed");

	// positions of one run follow with no gap
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap inside a run of positions");

	// once a position is blank, every higher position is blank
	a_blank_above: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last && segments == SEG_BLANK
			|=> segments == SEG_BLANK)
		else $error("digit or sign above a blank position");

	// a sign below the top position is followed by blanks
	a_minus_then_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last && segments == SEG_MINUS
			|=> segments == SEG_BLANK)
		else $error("non-blank position above the sign");

endmodule

bind signed_decimal_seven_segment_top sdss_checker u_sdss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.led_row   (led_row),
	.segments  (segments),
	.last      (last)
);
